FILE: src/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types, opcodes and fixed-point helpers for the vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

	// Opcodes carried in the op field.
	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_ADDS  = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_SCALE = 4'd4;
	localparam logic [3:0] OP_DOT   = 4'd5;
	localparam logic [3:0] OP_CROSS = 4'd6;
	localparam logic [3:0] OP_MAG   = 4'd7;
	localparam logic [3:0] OP_NORM  = 4'd8;

	// Q16.16 format and internal sizes.
	localparam int Q_FRAC     = 16;
	localparam int SUM_W      = 67;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 17;
	localparam int FIFO_DEPTH = 2;

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] scalar_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar_out;
		logic               fault;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               flag;
	} sat_t;

	// Clamp an exact value to the signed 32-bit range.
	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t r;
		r.flag = 1'b0;
		r.value = v[31:0];
		if (v > SAT_MAX) begin
			r.value = SAT_MAX[31:0];
			r.flag = 1'b1;
		end else if (v < SAT_MIN) begin
			r.value = SAT_MIN[31:0];
			r.flag = 1'b1;
		end
		return r;
	endfunction

	// Round an exact Q32.32 sum to Q16.16 (half toward plus infinity), then clamp.
	function automatic sat_t round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		t = v + ROUND_HALF;
		t = t >>> Q_FRAC;
		return sat32(t);
	endfunction

endpackage

FILE: src/v3alu_chan_if.sv
// ----------------------------------------------------------------------------
// v3alu_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface v3alu_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/v3alu_lane.sv
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: add/subtract, two multipliers, rounding and clamping.
// ----------------------------------------------------------------------------
module v3alu_lane (
	input  logic               clk,
	input  logic               en,
	input  logic [3:0]         op,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] s,
	input  logic signed [31:0] aj,
	input  logic signed [31:0] bk,
	input  logic signed [31:0] bj,
	input  logic signed [31:0] ak,
	output v3alu_pkg::sat_t    res,
	output logic signed [63:0] prod
);
	import v3alu_pkg::*;

	logic signed [31:0]       pa;
	logic signed [31:0]       pb;
	logic signed [32:0]       sum_a;
	logic signed [32:0]       sum_b;
	logic [3:0]               op_s2;
	logic signed [63:0]       p_s2;
	logic signed [63:0]       q_s2;
	logic signed [32:0]       add_s2;
	logic signed [SUM_W-1:0] cross_d;
	sat_t                     mul_r;
	sat_t                     add_r;
	sat_t                     res_c;

	// Pick the operands of the main multiplier for this opcode.
	always_comb begin
		pa = a;
		pb = b;
		case (op)
			OP_SCALE: pb = s;
			OP_CROSS: begin
				pa = aj;
				pb = bk;
			end
			OP_MAG, OP_NORM: pb = a;
			default: ;
		endcase
	end

	// Operands of the exact 33-bit adder.
	always_comb begin
		sum_a = {a[31], a};
		sum_b = {b[31], b};
		case (op)
			OP_ADDS: sum_b = {s[31], s};
			OP_SUB:  sum_b = -{b[31], b};
			default: ;
		endcase
	end

	// Products and sum are registered.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op;
			p_s2   <= pa * pb;
			q_s2   <= bj * ak;
			add_s2 <= sum_a + sum_b;
		end
	end

	// Exact difference for the cross product, then one rounding.
	always_comb begin
		cross_d = SUM_W'(p_s2);
		if (op_s2 == OP_CROSS) begin
			cross_d = SUM_W'(p_s2) - SUM_W'(q_s2);
		end
		mul_r = round_sat(cross_d);
		add_r = sat32(SUM_W'(add_s2));
		case (op_s2)
			OP_ADD, OP_ADDS, OP_SUB:     res_c = add_r;
			OP_MUL, OP_SCALE, OP_CROSS:  res_c = mul_r;
			default:                     res_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res  <= res_c;
			prod <= p_s2;
		end
	end

endmodule

FILE: src/v3alu_isqrt.sv
// ----------------------------------------------------------------------------
// v3alu_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v3alu_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root,
	output logic [32:0] rem
);
	import v3alu_pkg::*;

	logic [63:0] rad_q  [SQRT_STEPS];
	logic [63:0] root_q [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
		logic [63:0] s_cur;
		logic [63:0] r_cur;
		logic [64:0] trial;

		if (k == 0) begin : g_first
			assign s_cur = rad;
			assign r_cur = '0;
		end else begin : g_next
			assign s_cur = rad_q[k-1];
			assign r_cur = root_q[k-1];
		end

		assign trial = {1'b0, r_cur} + {1'b0, BIT};

		// Subtract the trial value when it fits and set the root bit.
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, s_cur} >= trial) begin
					rad_q[k]  <= s_cur - trial[63:0];
					root_q[k] <= (r_cur >> 1) + BIT;
				end else begin
					rad_q[k]  <= s_cur;
					root_q[k] <= r_cur >> 1;
				end
			end
		end
	end

	assign root = root_q[SQRT_STEPS-1][31:0];
	assign rem  = rad_q[SQRT_STEPS-1][32:0];

endmodule

FILE: src/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined restoring divider: round(u * 2^16 / m), one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3alu_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] u,
	input  logic [32:0] m,
	output logic [16:0] q
);
	import v3alu_pkg::*;

	localparam int DVD_W = 32 + Q_FRAC + 1;

	logic [DVD_W-1:0]     dvd;
	logic [32:0]          rem_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_q [DIV_STEPS];
	logic [32:0]          m_q   [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_q   [DIV_STEPS];

	// Dividend with the rounding bias; the quotient is known to fit DIV_STEPS bits.
	assign dvd = DVD_W'({u, {Q_FRAC{1'b0}}}) + DVD_W'(m >> 1);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [32:0]          r_cur;
		logic [DIV_STEPS-1:0] l_cur;
		logic [32:0]          m_cur;
		logic [DIV_STEPS-1:0] q_cur;
		logic [33:0]          t;
		logic [33:0]          mx;

		if (k == 0) begin : g_first
			assign r_cur = 33'(dvd[DVD_W-1:DIV_STEPS]);
			assign l_cur = dvd[DIV_STEPS-1:0];
			assign m_cur = m;
			assign q_cur = '0;
		end else begin : g_next
			assign r_cur = rem_q[k-1];
			assign l_cur = low_q[k-1];
			assign m_cur = m_q[k-1];
			assign q_cur = q_q[k-1];
		end

		assign t  = {r_cur, l_cur[DIV_STEPS-1-k]};
		assign mx = {1'b0, m_cur};

		// Bring in the next dividend bit and subtract when possible.
		always_ff @(posedge clk) begin
			if (en) begin
				low_q[k] <= l_cur;
				m_q[k]   <= m_cur;
				if (t >= mx) begin
					rem_q[k] <= 33'(t - mx);
					q_q[k]   <= q_cur | (DIV_STEPS'(1) << (DIV_STEPS - 1 - k));
				end else begin
					rem_q[k] <= t[32:0];
					q_q[k]   <= q_cur;
				end
			end
		end
	end

	assign q = q_q[DIV_STEPS-1];

endmodule

FILE: src/vec3_alu_top.sv
// ----------------------------------------------------------------------------
// vec3_alu_top
// Three-component Q16.16 vector ALU with saturation and a fault flag.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock unless stalled and returns one
// result per transaction, in order. Three lanes, one per component, hold the
// adders and multipliers; their products merge into the dot product and the
// sum of squares. Every opcode flows through the same pipeline: a 32-stage
// square root and a 17-stage divider set the latency. A two-entry output
// buffer lets the unit keep accepting while a result waits; the pipeline
// stalls only when both entries are full.
module vec3_alu_top (
	input logic        clk,
	input logic        arst_n,
	v3alu_chan_if.sink   cmd,
	v3alu_chan_if.source rsp
);
	import v3alu_pkg::*;

	localparam int N_VLD = 4 + SQRT_STEPS + 1 + DIV_STEPS;

	typedef struct packed {
		logic [3:0]       op;
		logic [2:0][31:0] a;
		rsp_t             res;
	} side_t;

	logic               en;
	logic               acc;
	logic               push;
	logic               pop;
	logic [N_VLD-1:0]   vld_q;
	logic [1:0]         cnt_q;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	rsp_t               fifo_q [FIFO_DEPTH];

	cmd_t               cmd_s1;
	logic signed [31:0] va [3];
	logic signed [31:0] vb [3];
	logic [3:0]         op_s2;
	logic [3:0]         op_s3;
	logic [2:0][31:0]   a_s2;
	logic [2:0][31:0]   a_s3;
	sat_t               lane_res  [3];
	logic signed [63:0] lane_prod [3];

	sat_t               dot_r;
	logic [63:0]        sumsq_c;
	rsp_t               res4_c;
	side_t              side_s4;
	logic [63:0]        sumsq_s4;

	logic [31:0]        sq_root;
	logic [32:0]        sq_rem;
	side_t              side_sq_q [SQRT_STEPS];

	logic [32:0]        root_x;
	logic [32:0]        m_c;
	side_t              side37_c;
	logic [31:0]        u_c [3];
	side_t              side_s37;
	logic [32:0]        m_s37;
	logic [31:0]        u_s37 [3];

	logic [16:0]        q_dv [3];
	side_t              side_dv_q [DIV_STEPS];
	side_t              side_f;
	logic [31:0]        rv [3];
	rsp_t               rsp_c;

	// Handshake and stall control.
	assign en        = (cnt_q != 2'(FIFO_DEPTH));
	assign cmd.ready = en;
	assign acc       = cmd.valid & en;
	assign push      = en & vld_q[N_VLD-1];
	assign pop       = rsp.valid & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[N_VLD-2:0], acc};
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd.data;
		end
	end

	assign va[0] = cmd_s1.ax;
	assign va[1] = cmd_s1.ay;
	assign va[2] = cmd_s1.az;
	assign vb[0] = cmd_s1.bx;
	assign vb[1] = cmd_s1.by;
	assign vb[2] = cmd_s1.bz;

	// Component lanes; lane i also forms the two cross terms of component i.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		v3alu_lane u_lane (
			.clk  (clk),
			.en   (en),
			.op   (cmd_s1.op),
			.a    (va[i]),
			.b    (vb[i]),
			.s    (cmd_s1.scalar_in),
			.aj   (va[J]),
			.bk   (vb[K]),
			.bj   (vb[J]),
			.ak   (va[K]),
			.res  (lane_res[i]),
			.prod (lane_prod[i])
		);
	end

	// Opcode and vector A follow the lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= cmd_s1.op;
			a_s2  <= {va[2], va[1], va[0]};
			op_s3 <= op_s2;
			a_s3  <= a_s2;
		end
	end

	// Merge the lanes: dot product, sum of squares and the early results.
	always_comb begin
		dot_r   = round_sat(SUM_W'(lane_prod[0]) + SUM_W'(lane_prod[1])
			+ SUM_W'(lane_prod[2]));
		sumsq_c = 64'(lane_prod[0]) + 64'(lane_prod[1]) + 64'(lane_prod[2]);
		res4_c  = '0;
		case (op_s3)
			OP_ADD, OP_ADDS, OP_SUB, OP_MUL, OP_SCALE, OP_CROSS: begin
				res4_c.rx    = lane_res[0].value;
				res4_c.ry    = lane_res[1].value;
				res4_c.rz    = lane_res[2].value;
				res4_c.fault = lane_res[0].flag | lane_res[1].flag | lane_res[2].flag;
			end
			OP_DOT: begin
				res4_c.scalar_out = dot_r.value;
				res4_c.fault      = dot_r.flag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.op  <= op_s3;
			side_s4.a   <= a_s3;
			side_s4.res <= res4_c;
			sumsq_s4    <= sumsq_c;
		end
	end

	// Square root of the sum of squares; side data travels alongside.
	v3alu_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sumsq_s4),
		.root (sq_root),
		.rem  (sq_rem)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq_q[0] <= side_s4;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				side_sq_q[k] <= side_sq_q[k-1];
			end
		end
	end

	// Round the magnitude, finish the magnitude opcode, fault a zero normalize.
	always_comb begin
		root_x   = {1'b0, sq_root};
		m_c      = root_x + 33'(sq_rem > root_x);
		side37_c = side_sq_q[SQRT_STEPS-1];
		case (side37_c.op)
			OP_MAG: begin
				if (m_c > 33'h0_7FFF_FFFF) begin
					side37_c.res.scalar_out = 32'h7FFF_FFFF;
					side37_c.res.fault      = 1'b1;
				end else begin
					side37_c.res.scalar_out = m_c[31:0];
				end
			end
			OP_NORM: begin
				if (m_c == '0) begin
					side37_c.res.fault = 1'b1;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			u_c[i] = side37_c.a[i][31] ? (32'd0 - side37_c.a[i]) : side37_c.a[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s37 <= side37_c;
			m_s37    <= m_c;
			u_s37    <= u_c;
		end
	end

	// One divider per component for normalization.
	for (genvar i = 0; i < 3; i++) begin : g_div
		v3alu_div u_div (
			.clk (clk),
			.en  (en),
			.u   (u_s37[i]),
			.m   (m_s37),
			.q   (q_dv[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dv_q[0] <= side_s37;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_dv_q[k] <= side_dv_q[k-1];
			end
		end
	end

	// Apply the signs to the normalized components and build the result.
	always_comb begin
		side_f = side_dv_q[DIV_STEPS-1];
		rsp_c  = side_f.res;
		for (int i = 0; i < 3; i++) begin
			rv[i] = side_f.a[i][31] ? (32'd0 - 32'(q_dv[i])) : 32'(q_dv[i]);
		end
		if ((side_f.op == OP_NORM) && !side_f.res.fault) begin
			rsp_c.rx = rv[0];
			rsp_c.ry = rv[1];
			rsp_c.rz = rv[2];
		end
	end

	// Output buffer.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= rsp_c;
		end
	end

	assign rsp.valid = (cnt_q != 2'd0);
	assign rsp.data  = fifo_q[rd_ptr_q];

endmodule

FILE: sim/vec3_alu_top_test.sv
// ----------------------------------------------------------------------------
// vec3_alu_top_test
// Self-checking bench for the Q16.16 vector ALU. A queue of commands feeds a
// driver and a monitor scores each result against an in-bench predictor.
// ----------------------------------------------------------------------------
module vec3_alu_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import v3alu_pkg::*;

	localparam int N_RANDOM    = 1000;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int PAUSE_AT    = 600;
	localparam int QUIET_LO    = 300;
	localparam int QUIET_HI    = 450;
	localparam int DRAIN_WAIT  = 120;

	logic clk;
	logic arst_n;

	v3alu_chan_if #(.payload_t(cmd_t)) cmd_if ();
	v3alu_chan_if #(.payload_t(rsp_t)) rsp_if ();

	vec3_alu_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	cmd_t cmd_queue[$];
	rsp_t alu_expected[$];
	int   n_sent;
	int   n_accepted;
	int   n_errors;
	bit   hold_done;
	int   hold_left;

	// Clock generation.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Clamp an exact value to 32 bits, noting saturation.
	function automatic logic signed [31:0] clamp32(input logic signed [95:0] v, inout bit f);
		if (v > 96'sd2147483647) begin
			f = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -96'sd2147483648) begin
			f = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Round an exact Q32.32 value to Q16.16, ties toward plus infinity.
	function automatic logic signed [31:0] round_q(input logic signed [95:0] v, inout bit f);
		return clamp32((v + 96'sd32768) >>> Q_FRAC, f);
	endfunction

	// Rounded magnitude of a vector, from the exact Q32.32 sum of squares.
	function automatic logic [65:0] magnitude(input logic signed [95:0] a[3]);
		logic [127:0] s;
		logic [127:0] r;
		logic [127:0] trial;
		logic [127:0] u;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			u = a[i] < 0 ? 128'(-a[i]) : 128'(a[i]);
			s += u * u;
		end
		r = '0;
		for (int i = 33; i >= 0; i--) begin
			trial = r | (128'd1 << i);
			if (trial * trial <= s)
				r = trial;
		end
		if (s - r * r > r)
			r++;
		return r[65:0];
	endfunction

	// Predicted result of one command.
	function automatic rsp_t alu_predict(input cmd_t c);
		rsp_t o;
		bit f;
		logic signed [95:0] a[3];
		logic signed [95:0] b[3];
		logic signed [95:0] s;
		logic signed [31:0] r[3];
		logic [65:0] m;
		logic [95:0] u;
		logic [95:0] q;
		a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
		b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
		s = c.scalar_in;
		f = 1'b0;
		r = '{default: '0};
		o = '0;
		case (c.op)
			OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], f);
			OP_ADDS: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + s, f);
			OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], f);
			OP_MUL: for (int i = 0; i < 3; i++) r[i] = round_q(a[i] * b[i], f);
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_q(a[i] * s, f);
			OP_DOT: o.scalar_out = round_q(a[0]*b[0] + a[1]*b[1] + a[2]*b[2], f);
			OP_CROSS: begin
				r[0] = round_q(a[1]*b[2] - b[1]*a[2], f);
				r[1] = round_q(b[0]*a[2] - a[0]*b[2], f);
				r[2] = round_q(a[0]*b[1] - b[0]*a[1], f);
			end
			OP_MAG: begin
				m = magnitude(a);
				o.scalar_out = clamp32(96'(m), f);
			end
			OP_NORM: begin
				m = magnitude(a);
				if (m == 0) begin
					f = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						u = a[i] < 0 ? 96'(-a[i]) : 96'(a[i]);
						q = (u * 96'd65536 + 96'(m / 2)) / 96'(m);
						r[i] = clamp32(a[i] < 0 ? -$signed(q) : $signed(q), f);
					end
				end
			end
			default: ;
		endcase
		if (c.op <= OP_NORM) begin
			o.rx = r[0];
			o.ry = r[1];
			o.rz = r[2];
			o.fault = f;
		end
		return o;
	endfunction

	// Operand value drawn from a mix of ranges.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 1 << 19) - (1 << 18);
			3: return $signed($urandom) >>> $urandom_range(1, 24);
			4: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					3: return 32'h1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(0, 1 << 22) - (1 << 21);
		endcase
	endfunction

	function automatic cmd_t make_cmd(input logic [3:0] op, input logic [31:0] ax,
		input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx,
		input logic [31:0] by, input logic [31:0] bz, input logic [31:0] sc);
		cmd_t c;
		c.op = op;
		c.ax = ax; c.ay = ay; c.az = az;
		c.bx = bx; c.by = by; c.bz = bz;
		c.scalar_in = sc;
		return c;
	endfunction

	// Report one mismatch and count it.
	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		$display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
		n_errors++;
	endtask

	// Driver: offers pending commands when free, with random gaps and one pause.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.data <= '0;
		end else if (!cmd_if.valid || cmd_if.ready) begin
			if (cmd_queue.size() == 0 ||
				(n_sent == PAUSE_AT &&
				 (alu_expected.size() != 0 || (cmd_if.valid && cmd_if.ready))) ||
				(!(n_sent >= QUIET_LO && n_sent < QUIET_HI) && $urandom_range(0, 99) < 7)) begin
				cmd_if.valid <= 1'b0;
			end else begin
				cmd_if.valid <= 1'b1;
				cmd_if.data <= cmd_queue.pop_front();
				n_sent <= n_sent + 1;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off to fill the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			rsp_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_if.ready <= (n_accepted >= QUIET_LO && n_accepted < QUIET_HI) ||
				$urandom_range(0, 99) >= 7;
		end
	end

	// Monitor: scores results, then records predictions for new commands.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (alu_expected.size() == 0) begin
					$display("%0t result with no command outstanding", $realtime);
					n_errors++;
				end else begin
					want = alu_expected.pop_front();
					if (rsp_if.data.rx !== want.rx)
						report_mismatch("rx", want.rx, rsp_if.data.rx);
					if (rsp_if.data.ry !== want.ry)
						report_mismatch("ry", want.ry, rsp_if.data.ry);
					if (rsp_if.data.rz !== want.rz)
						report_mismatch("rz", want.rz, rsp_if.data.rz);
					if (rsp_if.data.scalar_out !== want.scalar_out)
						report_mismatch("scalar_out", want.scalar_out, rsp_if.data.scalar_out);
					if (rsp_if.data.fault !== want.fault)
						report_mismatch("fault", 32'(want.fault), 32'(rsp_if.data.fault));
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				alu_expected.push_back(alu_predict(cmd_if.data));
				n_accepted <= n_accepted + 1;
			end
		end
	end

	// Run limit.
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// Stimulus and end of test.
	initial begin
		cmd_t c;
		logic [3:0] op;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		rsp_if.ready = 1'b0;
		n_sent = 0;
		n_accepted = 0;
		n_errors = 0;
		arst_n = 1'b0;

		// Directed: extremes, every opcode, rounding ties, zero normalize.
		cmd_queue.push_back(make_cmd(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h1,
			32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0));
		cmd_queue.push_back(make_cmd(OP_ADDS, 32'h80000000, 32'h7FFFFFFF, 32'h10000,
			0, 0, 0, 32'h80000000));
		cmd_queue.push_back(make_cmd(OP_ADDS, 32'h1, 32'h7FFFFFFF, 0, 0, 0, 0, 32'h7FFFFFFF));
		cmd_queue.push_back(make_cmd(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h30000,
			32'h7FFFFFFF, 32'h80000000, 32'h10000, 0));
		cmd_queue.push_back(make_cmd(OP_MUL, 32'h7FFFFFFF, 32'h80000000, 32'h8000,
			32'h7FFFFFFF, 32'h80000000, 32'h1, 0));
		cmd_queue.push_back(make_cmd(OP_MUL, 32'hFFFF8000, 32'h18000, 32'h10000,
			32'h1, 32'h18000, 32'hFFFF0000, 0));
		cmd_queue.push_back(make_cmd(OP_SCALE, 32'h20000, 32'hFFFF8000, 32'h7FFFFFFF,
			0, 0, 0, 32'h8000));
		cmd_queue.push_back(make_cmd(OP_SCALE, 32'h80000000, 32'h1, 32'h10000,
			0, 0, 0, 32'h80000000));
		cmd_queue.push_back(make_cmd(OP_DOT, 32'h10000, 32'h20000, 32'h30000,
			32'h40000, 32'h50000, 32'h60000, 0));
		cmd_queue.push_back(make_cmd(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 0));
		cmd_queue.push_back(make_cmd(OP_DOT, 32'h7FFFFFFF, 32'h80000000, 32'h0,
			32'h80000000, 32'h7FFFFFFF, 32'h0, 0));
		cmd_queue.push_back(make_cmd(OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0));
		cmd_queue.push_back(make_cmd(OP_CROSS, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0));
		cmd_queue.push_back(make_cmd(OP_MAG, 32'h30000, 32'h40000, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_MAG, 32'h80000000, 32'h80000000, 32'h80000000,
			0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_MAG, 0, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF));
		cmd_queue.push_back(make_cmd(OP_NORM, 32'h1, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 32'h80000000, 32'h7FFFFFFF, 32'h1, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 32'h30000, 32'hFFFC0000, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(4'd9, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		cmd_queue.push_back(make_cmd(4'd15, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));

		// Random commands, mostly valid opcodes.
		for (int i = 0; i < N_RANDOM; i++) begin
			op = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			c = make_cmd(op, pick_value(), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value(), pick_value());
			if ((op == OP_NORM || op == OP_MAG) && $urandom_range(0, 9) == 0) begin
				c.ax = '0;
				c.ay = '0;
				c.az = '0;
			end
			cmd_queue.push_back(c);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every command to be taken and every result to be scored.
		while (cmd_queue.size() != 0 || cmd_if.valid || alu_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
